FILE: rtl/banked_register_file_access_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the banked register file access block
// Concurrent property wrappers shared by the files that carry assertions.
// ---------------------------------------------------------------------------
`ifndef BANKED_REGISTER_FILE_ACCESS_MACROS_SVH
`define BANKED_REGISTER_FILE_ACCESS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle property failed");

`endif

FILE: rtl/bfa_pkg.sv
// ---------------------------------------------------------------------------
// Banked register file access package
// Transaction types, access codes and sizing constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int unsigned FileSizeDefault = 64;
  localparam int unsigned BankDepth       = 64;
  localparam int unsigned NumLanes        = 4;
  localparam int unsigned SpIndex         = 60;
  localparam logic [7:0]  SpReset         = 8'h07;

  localparam logic CmdRead  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  localparam logic [1:0] SizeByte   = 2'd0;
  localparam logic [1:0] SizeWord   = 2'd1;
  localparam logic [1:0] SizeDword  = 2'd2;
  localparam logic [1:0] SizeUnused = 2'd3;

  typedef struct packed {
    logic        command;
    logic [1:0]  access_size;
    logic [7:0]  reg_index;
    logic [1:0]  bank;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        index_error;
  } out_item_t;

endpackage

FILE: rtl/bfa_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/banked_register_file_access.sv
// ---------------------------------------------------------------------------
// Banked register file access
// Byte, word and dword reads and writes of a banked register file.
// ---------------------------------------------------------------------------
// Each input transaction on in_valid_i / in_stall_o carries one read or write
// of a byte, word or dword register. Exactly one result transaction follows
// on out_valid_o / out_stall_i, in order, holding the read data (zero for
// writes and errors) and the index error flag.
// A transaction is accepted at a rising edge where valid is high and stall
// is low. The result passes through the read stage and the output register
// before it is presented, and one transaction can be accepted in every
// cycle while the input is not stalled. This rate rests on the byte-lane
// RAMs, where the four bytes of any access fall into four different lanes,
// so each lane RAM sees a single read or write per access.
// Writes land at the accepting edge, so the next transaction already sees
// them. The read stage and the output register form a two-entry pipeline:
// while the receiver stalls, the block still takes a new transaction as long
// as the read stage is empty, and stalls its input only once both are full.
// Reset clears the pipeline and the per-byte valid flags at once; a byte that
// has not been written since reset reads as its reset value (zero, or 0x07
// for the stack pointer low byte). There is no clearing sweep.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "banked_register_file_access_macros.svh"

module banked_register_file_access
  import bfa_pkg::*;
#(
  parameter int unsigned FileSize = FileSizeDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  // The file is split into four byte lanes; lane L holds bytes with address
  // bits [1:0] equal to L.
  localparam int unsigned FileRows = (FileSize + NumLanes - 1) / NumLanes;
  localparam int unsigned FileRowW = $clog2(FileRows);
  localparam int unsigned BankRows = BankDepth / NumLanes;
  localparam int unsigned BankRowW = $clog2(BankRows);
  localparam int unsigned FileVldN = FileRows * NumLanes;

  // Decode of the incoming transaction.
  logic        accept;
  logic        idx_err;
  logic        banked;
  logic        sp_acc;
  logic        is_wr;
  logic [3:0]  off_ok;
  logic [7:0]  off_wbyte [NumLanes];

  // Per-lane addressing.
  logic [1:0]          lane_off   [NumLanes];
  logic [5:0]          lane_baddr [NumLanes];
  logic [8:0]          lane_faddr [NumLanes];
  logic [BankRowW-1:0] lane_brow  [NumLanes];
  logic [FileRowW-1:0] lane_frow  [NumLanes];
  logic [7:0]          lane_wdata [NumLanes];
  logic [3:0]          lane_bwe;
  logic [3:0]          lane_fwe;
  logic [3:0]          lane_bvld;
  logic [3:0]          lane_fvld;
  logic [3:0]          lane_spb;
  logic [7:0]          bank_rdata [NumLanes];
  logic [7:0]          file_rdata [NumLanes];

  // Valid flags: a byte not written since reset reads as its reset value.
  logic [BankDepth-1:0] bank_vld_q, bank_vld_d;
  logic [FileVldN-1:0]  file_vld_q, file_vld_d;

  // Read stage.
  logic        s1_valid_q;
  logic        s1_adv;
  logic        s1_wr_q;
  logic        s1_err_q;
  logic        s1_sp_q;
  logic        s1_banked_q;
  logic [1:0]  s1_size_q;
  logic [1:0]  s1_lo_q;
  logic [3:0]  s1_ok_q;
  logic [3:0]  s1_bvld_q;
  logic [3:0]  s1_fvld_q;
  logic [3:0]  s1_spb_q;

  // Output register.
  logic        out_valid_q;
  out_item_t   out_data_q;
  out_item_t   out_data_d;

  logic [7:0]  lane_byte [NumLanes];
  logic [7:0]  off_byte  [NumLanes];

  // The read stage moves on when the output register is empty or is being
  // taken; the input stalls only when the read stage is full and blocked.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    logic [8:0] fa;
    idx_err = ({1'b0, in_data_i.reg_index} >= 9'(FileSize));
    banked  = (in_data_i.reg_index < 8'd8);
    is_wr   = (in_data_i.command == CmdWrite);
    // The stack pointer pair is a dword at index 60, stored little-endian.
    sp_acc  = (in_data_i.access_size == SizeDword) &&
              (in_data_i.reg_index == 8'(SpIndex));
    for (int i = 0; i < NumLanes; i++) begin
      off_wbyte[i] = 8'h00;
    end
    unique case (in_data_i.access_size)
      SizeByte: begin
        off_ok         = 4'b0001;
        off_wbyte[0]   = in_data_i.write_data[7:0];
      end
      SizeWord: begin
        off_ok         = 4'b0011;
        off_wbyte[0]   = in_data_i.write_data[15:8];
        off_wbyte[1]   = in_data_i.write_data[7:0];
      end
      SizeDword: begin
        if (sp_acc) begin
          // Low 16 bits little-endian; the upper two bytes are cleared on a
          // write and not read.
          off_ok       = is_wr ? 4'b1111 : 4'b0011;
          off_wbyte[0] = in_data_i.write_data[7:0];
          off_wbyte[1] = in_data_i.write_data[15:8];
        end else begin
          off_ok       = 4'b1111;
          off_wbyte[0] = in_data_i.write_data[31:24];
          off_wbyte[1] = in_data_i.write_data[23:16];
          off_wbyte[2] = in_data_i.write_data[15:8];
          off_wbyte[3] = in_data_i.write_data[7:0];
        end
      end
      default: begin
        off_ok         = 4'b0000;
      end
    endcase
    if (idx_err) begin
      off_ok = 4'b0000;
    end
    // Bytes beyond the end of the file read zero and drop their writes.
    for (int i = 0; i < NumLanes; i++) begin
      fa = {1'b0, in_data_i.reg_index} + 9'(i);
      if (!banked && (fa >= 9'(FileSize))) begin
        off_ok[i] = 1'b0;
      end
    end
  end

  always_comb begin
    bank_vld_d = bank_vld_q;
    file_vld_d = file_vld_q;
    for (int l = 0; l < NumLanes; l++) begin
      lane_off[l]   = 2'(l) - in_data_i.reg_index[1:0];
      // A banked access runs on into the next bank and wraps within 64 bytes.
      lane_baddr[l] = {1'b0, in_data_i.bank, in_data_i.reg_index[2:0]} +
                      {4'b0000, lane_off[l]};
      lane_faddr[l] = {1'b0, in_data_i.reg_index} + {7'd0, lane_off[l]};
      lane_brow[l]  = lane_baddr[l][2 +: BankRowW];
      lane_frow[l]  = lane_faddr[l][2 +: FileRowW];
      lane_wdata[l] = off_wbyte[lane_off[l]];
      lane_bwe[l]   = accept && is_wr && banked && off_ok[lane_off[l]];
      lane_fwe[l]   = accept && is_wr && !banked && off_ok[lane_off[l]];
      lane_bvld[l]  = bank_vld_q[lane_baddr[l]];
      lane_fvld[l]  = file_vld_q[{lane_frow[l], 2'(l)}];
      lane_spb[l]   = (lane_faddr[l] == 9'(SpIndex));
      if (lane_bwe[l]) begin
        bank_vld_d[lane_baddr[l]] = 1'b1;
      end
      if (lane_fwe[l]) begin
        file_vld_d[{lane_frow[l], 2'(l)}] = 1'b1;
      end
    end
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    bfa_ram #(
      .Width(8),
      .Depth(BankRows)
    ) u_bank_ram (
      .clk_i  (clk_i),
      .we_i   (lane_bwe[l]),
      .waddr_i(lane_brow[l]),
      .wdata_i(lane_wdata[l]),
      .re_i   (accept),
      .raddr_i(lane_brow[l]),
      .rdata_o(bank_rdata[l])
    );

    bfa_ram #(
      .Width(8),
      .Depth(FileRows)
    ) u_file_ram (
      .clk_i  (clk_i),
      .we_i   (lane_fwe[l]),
      .waddr_i(lane_frow[l]),
      .wdata_i(lane_wdata[l]),
      .re_i   (accept),
      .raddr_i(lane_frow[l]),
      .rdata_o(file_rdata[l])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_vld_q  <= '0;
      file_vld_q  <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bank_vld_q <= bank_vld_d;
      file_vld_q <= file_vld_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Read-stage side information is captured together with the RAM reads.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_wr_q     <= is_wr;
      s1_err_q    <= idx_err;
      s1_sp_q     <= sp_acc;
      s1_banked_q <= banked;
      s1_size_q   <= in_data_i.access_size;
      s1_lo_q     <= in_data_i.reg_index[1:0];
      s1_ok_q     <= off_ok;
      s1_bvld_q   <= lane_bvld;
      s1_fvld_q   <= lane_fvld;
      s1_spb_q    <= lane_spb;
    end
    if (s1_adv) begin
      out_data_q <= out_data_d;
    end
  end

  // Result assembly from the lane bytes.
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      if (s1_banked_q) begin
        lane_byte[l] = s1_bvld_q[l] ? bank_rdata[l] : 8'h00;
      end else if (s1_fvld_q[l]) begin
        lane_byte[l] = file_rdata[l];
      end else begin
        lane_byte[l] = s1_spb_q[l] ? SpReset : 8'h00;
      end
    end
    for (int i = 0; i < NumLanes; i++) begin
      off_byte[i] = lane_byte[2'(s1_lo_q + 2'(i))] & {8{s1_ok_q[i]}};
    end
    out_data_d.index_error = s1_err_q;
    unique case (s1_size_q)
      SizeByte:  out_data_d.read_data = {24'd0, off_byte[0]};
      SizeWord:  out_data_d.read_data = {16'd0, off_byte[0], off_byte[1]};
      SizeDword: begin
        if (s1_sp_q) begin
          out_data_d.read_data = {16'd0, off_byte[1], off_byte[0]};
        end else begin
          out_data_d.read_data = {off_byte[0], off_byte[1], off_byte[2], off_byte[3]};
        end
      end
      default:   out_data_d.read_data = 32'd0;
    endcase
    if (s1_wr_q) begin
      out_data_d.read_data = 32'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // An accepted transaction always occupies the read stage in the next cycle.
  `BFA_ASSERT_NEXT(a_accept_fills_s1, clk_i, rst_ni, accept, s1_valid_q)
  // A result only appears after the read stage held a transaction.
  `BFA_ASSERT_NOW(a_out_from_s1, clk_i, rst_ni, $rose(out_valid_q), $past(s1_valid_q))
  // Writes and index errors return zero read data.
  `BFA_ASSERT_NEXT(a_write_reads_zero, clk_i, rst_ni, s1_adv && (s1_wr_q || s1_err_q),
                   out_data_o.read_data == 32'd0)
  // An index error is reported exactly when the transaction carried one.
  `BFA_ASSERT_NEXT(a_err_carried, clk_i, rst_ni, s1_adv,
                   out_data_o.index_error == $past(s1_err_q))

endmodule

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// Testbench for the banked register file access block
// Checks byte, word and dword reads and writes against a behavioural model
// of the banked bytes and the register file, using directed and random
// transactions with random idling on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
  import bfa_pkg::*;
;

  // The block is instantiated with its default file size, and the model
  // below is sized to match.
  localparam int unsigned FileSize   = FileSizeDefault;
  localparam int unsigned NumRandom  = 1000;
  localparam int unsigned MaxIdle    = 12;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned DrainWait  = 10;

  // -------------------------------------------------------------------------
  // Clock, reset and the signals that the block sees. Every input has a known
  // value from time zero.
  // -------------------------------------------------------------------------
  logic      clk_i     = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b1;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  banked_register_file_access i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // -------------------------------------------------------------------------
  // Model of the storage. The banked bytes hold all four banks, eight bytes
  // each, followed by spare entries that a spilling access may reach.
  // -------------------------------------------------------------------------
  logic [7:0] bank_mem [BankDepth];
  logic [7:0] file_mem [FileSize];

  in_item_t  pending_accesses [$];
  out_item_t expected_results [$];

  int unsigned mismatches = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned quiet_cnt  = 0;

  // One stretch in four, selected by cycle counter bits [8:7], draws no idle
  // time on either side, so that back-to-back traffic is covered as well.
  logic calm;
  assign calm = (cycle_cnt[8:7] == 2'b11);

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic int unsigned idle_draw();
    if (calm) begin
      return 0;
    end
    return $urandom_range(MaxIdle, 0);
  endfunction

  // A byte of an access. Banked indices address bank*8 + index + offset and
  // wrap within the banked store; file bytes past the end read as zero.
  function automatic logic [7:0] peek_byte(int unsigned idx, int unsigned bk,
                                           int unsigned off);
    if (idx < 8) begin
      return bank_mem[(bk * 8 + idx + off) % BankDepth];
    end
    if (idx + off < FileSize) begin
      return file_mem[idx + off];
    end
    return 8'h00;
  endfunction

  // Writes past the end of the file are dropped.
  function automatic void poke_byte(int unsigned idx, int unsigned bk,
                                    int unsigned off, logic [7:0] val);
    if (idx < 8) begin
      bank_mem[(bk * 8 + idx + off) % BankDepth] = val;
    end else if (idx + off < FileSize) begin
      file_mem[idx + off] = val;
    end
  endfunction

  // Carries out one access on the model and returns the result that the
  // block must give for it.
  function automatic out_item_t regfile_access(in_item_t acc);
    out_item_t   res;
    int unsigned nbytes;
    int unsigned idx;
    int unsigned bk;
    logic        is_wr;
    res   = '0;
    idx   = acc.reg_index;
    bk    = acc.bank;
    is_wr = (acc.command == CmdWrite);
    case (acc.access_size)
      SizeByte:  nbytes = 1;
      SizeWord:  nbytes = 2;
      SizeDword: nbytes = 4;
      default:   nbytes = 0;
    endcase
    if (idx >= FileSize) begin
      // Index error: flagged, reads zero, write dropped.
      res.index_error = 1'b1;
    end else if (acc.access_size == SizeDword && idx == SpIndex) begin
      // The stack pointer pair is little-endian; a write clears the top half.
      if (is_wr) begin
        poke_byte(idx, bk, 0, acc.write_data[7:0]);
        poke_byte(idx, bk, 1, acc.write_data[15:8]);
        poke_byte(idx, bk, 2, 8'h00);
        poke_byte(idx, bk, 3, 8'h00);
      end else begin
        res.read_data = {16'h0000, peek_byte(idx, bk, 1), peek_byte(idx, bk, 0)};
      end
    end else begin
      // Big-endian: the lowest index holds the most significant byte.
      for (int unsigned i = 0; i < nbytes; i++) begin
        if (is_wr) begin
          poke_byte(idx, bk, i, 8'(acc.write_data >> (8 * (nbytes - 1 - i))));
        end else begin
          res.read_data |= 32'(peek_byte(idx, bk, i)) << (8 * (nbytes - 1 - i));
        end
      end
    end
    if (is_wr) begin
      res.read_data = '0;
    end
    return res;
  endfunction

  task automatic queue_access(logic cmd, logic [1:0] size, logic [7:0] idx,
                              logic [1:0] bk, logic [31:0] wdata);
    in_item_t acc;
    acc.command     = cmd;
    acc.access_size = size;
    acc.reg_index   = idx;
    acc.bank        = bk;
    acc.write_data  = wdata;
    pending_accesses.push_back(acc);
  endtask

  // Random access. Most transactions hit valid registers, with extra weight
  // on the banked bytes, the end of the file and the stack pointer pair, so
  // that reads regularly return data written earlier. The remainder are bad
  // indices and the unused size.
  function automatic in_item_t random_access();
    in_item_t    acc;
    int unsigned pick;
    acc.command    = 1'($urandom_range(1, 0));
    acc.bank       = 2'($urandom_range(3, 0));
    acc.write_data = $urandom();
    pick = $urandom_range(99, 0);
    if (pick < 5) begin
      acc.access_size = 2'($urandom_range(3, 0));
    end else begin
      acc.access_size = 2'($urandom_range(2, 0));
    end
    pick = $urandom_range(99, 0);
    if (pick < 35) begin
      acc.reg_index = 8'($urandom_range(7, 0));
    end else if (pick < 65) begin
      acc.reg_index = 8'($urandom_range(FileSize - 1, 8));
    end else if (pick < 80) begin
      acc.reg_index = 8'($urandom_range(FileSize - 1, FileSize - 8));
    end else if (pick < 90) begin
      acc.reg_index   = 8'(SpIndex);
      acc.access_size = SizeDword;
    end else begin
      acc.reg_index = 8'($urandom_range(255, FileSize));
    end
    return acc;
  endfunction

  // -------------------------------------------------------------------------
  // Driver. Presents queued transactions after a random number of idle
  // cycles; a presented transaction is held until it is accepted. The model
  // is updated at acceptance, so it follows the block's order exactly.
  // -------------------------------------------------------------------------
  int unsigned drv_wait = 0;

  always @(posedge clk_i) begin : driver
    logic taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_wait = idle_draw();
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        expected_results.push_back(regfile_access(in_data));
        drv_wait = idle_draw();
      end
      if (!in_valid || taken) begin
        if (drv_wait == 0 && pending_accesses.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_accesses.pop_front();
        end else begin
          in_valid <= 1'b0;
          if (drv_wait > 0) begin
            drv_wait = drv_wait - 1;
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor. Stalls the result channel for a random number of cycles after
  // each accepted result and compares every accepted result with the oldest
  // outstanding expectation.
  // -------------------------------------------------------------------------
  int unsigned mon_wait = 0;

  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b1;
      mon_wait = idle_draw();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing outstanding: read_data %h index_error %b",
                 out_data.read_data, out_data.index_error);
          mismatches = mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_data.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, out_data.read_data);
            mismatches = mismatches + 1;
          end
          if (out_data.index_error !== want.index_error) begin
            $error("index_error: expected %b, got %b", want.index_error,
                   out_data.index_error);
            mismatches = mismatches + 1;
          end
        end
        mon_wait = idle_draw();
      end
      if (mon_wait > 0) begin
        out_stall <= 1'b1;
        mon_wait = mon_wait - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog. Counts cycles in which neither channel completes a transaction;
  // a block that has hung ends the run.
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cnt <= 0;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
      if (quiet_cnt >= QuietLimit) begin
        $display("timeout: no transaction for %0d cycles", QuietLimit);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus and end of run.
  // -------------------------------------------------------------------------
  initial begin
    // Model state after reset: all zero apart from the stack pointer low byte.
    for (int unsigned i = 0; i < BankDepth; i++) begin
      bank_mem[i] = 8'h00;
    end
    for (int unsigned i = 0; i < FileSize; i++) begin
      file_mem[i] = 8'h00;
    end
    if (SpIndex < FileSize) begin
      file_mem[SpIndex] = SpReset;
    end

    // Directed part. The stack pointer is read at its reset value first.
    queue_access(CmdRead,  SizeDword,  8'(SpIndex), 2'd0, 32'h0);
    queue_access(CmdRead,  SizeByte,   8'd0,        2'd0, 32'h0);
    // Banked bytes in every bank, with data bits above the size set.
    queue_access(CmdWrite, SizeByte,   8'd0,        2'd0, 32'hFFFF_FFA5);
    queue_access(CmdWrite, SizeWord,   8'd3,        2'd1, 32'hDEAD_BEEF);
    queue_access(CmdWrite, SizeDword,  8'd6,        2'd2, 32'h1234_5678);
    queue_access(CmdWrite, SizeDword,  8'd7,        2'd3, 32'hFFFF_FFFF);
    queue_access(CmdRead,  SizeDword,  8'd0,        2'd0, 32'hFFFF_FFFF);
    // Spill of a banked dword into the next bank.
    queue_access(CmdRead,  SizeDword,  8'd6,        2'd2, 32'h0);
    queue_access(CmdRead,  SizeByte,   8'd0,        2'd3, 32'h0);
    queue_access(CmdRead,  SizeWord,   8'd2,        2'd3, 32'h0);
    // File bytes, including the lowest index.
    queue_access(CmdWrite, SizeByte,   8'd8,        2'd3, 32'hFFFF_FFFF);
    queue_access(CmdWrite, SizeDword,  8'd40,       2'd0, 32'hA1B2_C3D4);
    queue_access(CmdRead,  SizeWord,   8'd41,       2'd0, 32'h0);
    // Stack pointer pair: write, then read it and the cleared bytes.
    queue_access(CmdWrite, SizeWord,   8'd62,       2'd0, 32'h0000_BBCC);
    queue_access(CmdWrite, SizeDword,  8'(SpIndex), 2'd1, 32'hFFFF_FFFF);
    queue_access(CmdRead,  SizeDword,  8'(SpIndex), 2'd0, 32'h0);
    queue_access(CmdRead,  SizeWord,   8'd62,       2'd0, 32'h0);
    queue_access(CmdRead,  SizeWord,   8'd60,       2'd0, 32'h0);
    // Accesses that run past the end of the file.
    queue_access(CmdWrite, SizeDword,  8'd62,       2'd0, 32'h5566_7788);
    queue_access(CmdRead,  SizeDword,  8'd62,       2'd0, 32'h0);
    queue_access(CmdRead,  SizeWord,   8'd63,       2'd0, 32'h0);
    // Bad indices and the unused size.
    queue_access(CmdWrite, SizeByte,   8'd64,       2'd0, 32'hFFFF_FFFF);
    queue_access(CmdRead,  SizeDword,  8'd255,      2'd3, 32'h0);
    queue_access(CmdWrite, SizeUnused, 8'd10,       2'd2, 32'hFFFF_FFFF);
    queue_access(CmdRead,  SizeUnused, 8'd200,      2'd1, 32'h0);

    for (int unsigned n = 0; n < NumRandom; n++) begin
      pending_accesses.push_back(random_access());
    end

    // Hold reset, then release it through the same edge-driven path as the other inputs.
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;

    // Wait until all transactions are in and every result has been checked,
    // then wait a while longer for anything stray to show up.
    while (pending_accesses.size() > 0 || in_valid || expected_results.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DrainWait) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bfa_pkg.sv
rtl/bfa_ram.sv
rtl/banked_register_file_access.sv
tb/tb_top.sv
